FILE: rtl/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg: shared definitions of the brace indent reformatter
// Result kinds, register map, default configuration and the stack control
// bundle used between the top level and the indent stack.
// ----------------------------------------------------------------------------
package bir_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam int RUN_DEPTH_DEF   = 16;
    localparam int PART_WIDTH_DEF  = 16;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_INDENT = 2'd1;
    localparam logic [1:0] KIND_EOL    = 2'd2;

    localparam logic [2:0] REG_OPENER_LOW  = 3'd0;
    localparam logic [2:0] REG_OPENER_HIGH = 3'd1;
    localparam logic [2:0] REG_CLOSER_LOW  = 3'd2;
    localparam logic [2:0] REG_CLOSER_HIGH = 3'd3;
    localparam logic [2:0] REG_SPACES      = 3'd4;
    localparam logic [2:0] REG_PROGRESSIVE = 3'd5;
    localparam logic [2:0] REG_LEAD_DEDENT = 3'd6;

    localparam logic [63:0] OPENER_LOW_RST  = 64'd0;
    localparam logic [63:0] OPENER_HIGH_RST = 64'h0800_0000_0000_0000;
    localparam logic [63:0] CLOSER_LOW_RST  = 64'd0;
    localparam logic [63:0] CLOSER_HIGH_RST = 64'h2000_0000_0000_0000;
    localparam logic [7:0]  SPACES_RST      = 8'd4;

    localparam logic [1:0] PH_STRIP = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // One operation per cycle on the whole chain of stack cells.
    typedef struct packed {
        logic push;
        logic pop;
        logic load;
    } stack_op_t;

endpackage

FILE: rtl/brace_indent_reformatter.sv
// ----------------------------------------------------------------------------
// brace_indent_reformatter: re-indents a text stream by brace nesting
// Input channel (in_valid/in_ready): one byte or one end-of-line marker per
// transfer. Output channel (out_valid/out_ready): indent runs, bytes and
// end-of-line markers, the last result of an input marked by last.
// One item at a time: an item that yields results passes through the pop,
// multiply, net and emit states before its first result is registered; a
// dedent retires or trims one indent part per pop step (the shifting stack
// handles one part per cycle), an end of line that dedents goes back through
// the pop state, and the results then leave one per cycle while the receiver
// takes them. Leading whitespace and buffered leading closers yield nothing.
// A new item is taken once the previous item's last result is in the output
// register; a stalled receiver holds the output register and, after that,
// the input channel.
// Reset empties the stack, the closer run and the line state and loads the
// default configuration; the stack entries themselves are never cleared.
// Configuration is an APB-style port with 64-bit registers at 8-byte steps.
// ----------------------------------------------------------------------------
module brace_indent_reformatter #(
    parameter int STACK_DEPTH = bir_pkg::STACK_DEPTH_DEF,
    parameter int RUN_DEPTH   = bir_pkg::RUN_DEPTH_DEF,
    parameter int PART_WIDTH  = bir_pkg::PART_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_char,
    output logic [15:0] space_count,
    output logic        overflow,
    output logic        last
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SUM_W = PART_WIDTH + CNT_W;
    localparam int LW    = (SUM_W > 17) ? SUM_W : 17;
    localparam int CW    = (PART_WIDTH > 16) ? PART_WIDTH : 16;
    localparam int CC_W  = $clog2(RUN_DEPTH + 1);
    localparam int RI_W  = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam logic [31:0] PART_MAX = 32'((64'd1 << PART_WIDTH) - 64'd1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_NET  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    // Configuration registers.
    logic [63:0] opl_reg, oph_reg, cll_reg, clh_reg;
    logic [7:0]  spl_reg;
    logic        prog_reg, lcd_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opl_reg  <= bir_pkg::OPENER_LOW_RST;
            oph_reg  <= bir_pkg::OPENER_HIGH_RST;
            cll_reg  <= bir_pkg::CLOSER_LOW_RST;
            clh_reg  <= bir_pkg::CLOSER_HIGH_RST;
            spl_reg  <= bir_pkg::SPACES_RST;
            prog_reg <= 1'b1;
            lcd_reg  <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                bir_pkg::REG_OPENER_LOW:  opl_reg  <= pwdata;
                bir_pkg::REG_OPENER_HIGH: oph_reg  <= pwdata;
                bir_pkg::REG_CLOSER_LOW:  cll_reg  <= pwdata;
                bir_pkg::REG_CLOSER_HIGH: clh_reg  <= pwdata;
                bir_pkg::REG_SPACES:      spl_reg  <= pwdata[7:0];
                bir_pkg::REG_PROGRESSIVE: prog_reg <= pwdata[0];
                bir_pkg::REG_LEAD_DEDENT: lcd_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bir_pkg::REG_OPENER_LOW:  prdata = opl_reg;
            bir_pkg::REG_OPENER_HIGH: prdata = oph_reg;
            bir_pkg::REG_CLOSER_LOW:  prdata = cll_reg;
            bir_pkg::REG_CLOSER_HIGH: prdata = clh_reg;
            bir_pkg::REG_SPACES:      prdata = {56'd0, spl_reg};
            bir_pkg::REG_PROGRESSIVE: prdata = {63'd0, prog_reg};
            bir_pkg::REG_LEAD_DEDENT: prdata = {63'd0, lcd_reg};
            default:                  prdata = 64'd0;
        endcase
    end

    // Character classes.
    logic [127:0] op_map, cl_map;
    logic         is_op, is_cl, is_ws;

    assign op_map = {oph_reg, opl_reg};
    assign cl_map = {clh_reg, cll_reg};
    assign is_op  = !character[7] && op_map[character[6:0]];
    assign is_cl  = !character[7] && cl_map[character[6:0]];
    assign is_ws  = (character == bir_pkg::SPACE_CHAR) ||
                    ((character >= 8'd9) && (character <= 8'd13));

    // Control and line state.
    logic [2:0]            state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic signed [15:0]    net_reg, net_next;
    logic [CC_W-1:0]       ccount_reg, ccount_next;
    logic [7:0]            cbuf_reg [RUN_DEPTH];
    logic                  cbuf_we;
    logic [RI_W-1:0]       cbuf_widx;
    logic [15:0]           amount_reg, amount_next;
    logic                  second_reg, second_next;
    logic                  wind_reg, wind_next;
    logic                  wchar_reg, wchar_next;
    logic                  weol_reg, weol_next;
    logic [7:0]            char_reg, char_next;
    logic [CC_W-1:0]       en_reg, en_next;
    logic [CC_W-1:0]       ei_reg, ei_next;
    logic                  ovf_reg, ovf_next;
    logic signed [15:0]    netop_reg, netop_next;
    logic [15:0]           sc_reg, sc_next;

    logic                  ov_reg, ov_next;
    logic [1:0]            okind_reg, okind_next;
    logic [7:0]            ochar_reg, ochar_next;
    logic [15:0]           osc_reg, osc_next;
    logic                  oovf_reg, oovf_next;
    logic                  olast_reg, olast_next;

    bir_pkg::stack_op_t    stk_op;
    logic [PART_WIDTH-1:0] stk_din, stk_top;

    bir_stack #(
        .STACK_DEPTH(STACK_DEPTH),
        .PART_WIDTH (PART_WIDTH)
    ) u_stack (
        .clk(clk),
        .op (stk_op),
        .din(stk_din),
        .top(stk_top)
    );

    // Datapath helpers.
    logic [CW-1:0]      amt_w, top_w, taken_w, rest_w;
    logic [LW-1:0]      level;
    logic [23:0]        prod;
    logic               sc_sat;
    logic [31:0]        push_v, push_sat_v;
    logic               push_sat;
    logic signed [15:0] body_n1, body_n2;
    logic               body_ovf;
    logic [16:0]        neg_net;

    always_comb
    begin
        amt_w   = CW'(amount_reg);
        top_w   = CW'(stk_top);
        taken_w = (amt_w > top_w) ? top_w : amt_w;
        rest_w  = top_w - taken_w;

        level  = prog_reg ? LW'(count_reg) : LW'(sum_reg);
        prod   = level[15:0] * spl_reg;
        sc_sat = ((|level[LW-1:16]) && (spl_reg != 8'd0)) || (prod[23:16] != 8'd0);

        push_v     = 32'(netop_reg[15:0]);
        push_sat   = push_v > PART_MAX;
        push_sat_v = push_sat ? PART_MAX : push_v;
        neg_net    = 17'd0 - {netop_reg[15], netop_reg};

        body_ovf = 1'b0;
        body_n1  = net_reg;
        if (is_op)
        begin
            if (net_reg == 16'sd32767)
            begin
                body_ovf = 1'b1;
            end
            else
            begin
                body_n1 = net_reg + 16'sd1;
            end
        end
        body_n2 = body_n1;
        if (is_cl)
        begin
            if (body_n1 == -16'sd32768)
            begin
                body_ovf = 1'b1;
            end
            else
            begin
                body_n2 = body_n1 - 16'sd1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        net_next    = net_reg;
        ccount_next = ccount_reg;
        cbuf_we     = 1'b0;
        cbuf_widx   = ccount_reg[RI_W-1:0];
        amount_next = amount_reg;
        second_next = second_reg;
        wind_next   = wind_reg;
        wchar_next  = wchar_reg;
        weol_next   = weol_reg;
        char_next   = char_reg;
        en_next     = en_reg;
        ei_next     = ei_reg;
        ovf_next    = ovf_reg;
        netop_next  = netop_reg;
        sc_next     = sc_reg;
        stk_op      = '{push: 1'b0, pop: 1'b0, load: 1'b0};
        stk_din     = PART_WIDTH'(rest_w);

        ov_next    = ov_reg && !out_ready;
        okind_next = okind_reg;
        ochar_next = ochar_reg;
        osc_next   = osc_reg;
        oovf_next  = oovf_reg;
        olast_next = olast_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    amount_next = 16'd0;
                    second_next = 1'b0;
                    wind_next   = 1'b0;
                    wchar_next  = 1'b0;
                    weol_next   = 1'b0;
                    char_next   = character;
                    en_next     = '0;
                    ei_next     = '0;
                    ovf_next    = 1'b0;
                    if (action)
                    begin
                        if (phase_reg == bir_pkg::PH_RUN)
                        begin
                            amount_next = 16'(ccount_reg);
                            wind_next   = 1'b1;
                            en_next     = ccount_reg;
                        end
                        weol_next   = 1'b1;
                        netop_next  = net_reg;
                        net_next    = 16'sd0;
                        phase_next  = bir_pkg::PH_STRIP;
                        ccount_next = '0;
                        state_next  = S_POP;
                    end
                    else
                    begin
                        case (phase_reg)
                            bir_pkg::PH_STRIP:
                            begin
                                if (is_ws)
                                begin
                                    state_next = S_IDLE;
                                end
                                else if (lcd_reg && is_cl)
                                begin
                                    cbuf_we     = 1'b1;
                                    cbuf_widx   = '0;
                                    ccount_next = CC_W'(1);
                                    phase_next  = bir_pkg::PH_RUN;
                                end
                                else
                                begin
                                    wind_next  = 1'b1;
                                    wchar_next = 1'b1;
                                    ovf_next   = body_ovf;
                                    net_next   = body_n2;
                                    phase_next = bir_pkg::PH_BODY;
                                    state_next = S_POP;
                                end
                            end
                            bir_pkg::PH_RUN:
                            begin
                                if (is_cl && (ccount_reg < CC_W'(RUN_DEPTH)))
                                begin
                                    cbuf_we     = 1'b1;
                                    ccount_next = ccount_reg + CC_W'(1);
                                end
                                else
                                begin
                                    // Any other byte, or a closer that no longer fits, flushes the run.
                                    amount_next = 16'(ccount_reg);
                                    wind_next   = 1'b1;
                                    en_next     = ccount_reg;
                                    ccount_next = '0;
                                    wchar_next  = 1'b1;
                                    ovf_next    = body_ovf || is_cl;
                                    net_next    = body_n2;
                                    phase_next  = bir_pkg::PH_BODY;
                                    state_next  = S_POP;
                                end
                            end
                            default:
                            begin
                                wchar_next = 1'b1;
                                ovf_next   = body_ovf;
                                net_next   = body_n2;
                                phase_next = bir_pkg::PH_BODY;
                                state_next = S_POP;
                            end
                        endcase
                    end
                end
            end

            S_POP:
            begin
                if ((amount_reg == 16'd0) || (count_reg == '0))
                begin
                    state_next = second_reg ? S_EMIT : S_MUL;
                end
                else
                begin
                    // Retire as much of the top part as the remaining amount covers.
                    amount_next = amount_reg - taken_w[15:0];
                    sum_next    = sum_reg - SUM_W'(taken_w);
                    if (rest_w == '0)
                    begin
                        stk_op.pop = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        stk_op.load = 1'b1;
                    end
                end
            end

            S_MUL:
            begin
                sc_next = sc_sat ? 16'hFFFF : prod[15:0];
                if (wind_reg && sc_sat)
                begin
                    ovf_next = 1'b1;
                end
                state_next = S_NET;
            end

            S_NET:
            begin
                state_next = S_EMIT;
                if (weol_reg && (netop_reg > 16'sd0))
                begin
                    if (count_reg >= CNT_W'(STACK_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (push_sat)
                        begin
                            ovf_next = 1'b1;
                        end
                        stk_op.push = 1'b1;
                        stk_din     = PART_WIDTH'(push_sat_v);
                        count_next  = count_reg + CNT_W'(1);
                        sum_next    = sum_reg + SUM_W'(push_sat_v);
                    end
                end
                else if (weol_reg && (netop_reg < 16'sd0))
                begin
                    amount_next = neg_net[15:0];
                    second_next = 1'b1;
                    state_next  = S_POP;
                end
            end

            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    oovf_next  = ovf_reg;
                    ochar_next = 8'd0;
                    osc_next   = 16'd0;
                    if (wind_reg)
                    begin
                        wind_next  = 1'b0;
                        okind_next = bir_pkg::KIND_INDENT;
                        osc_next   = sc_reg;
                        olast_next = !((en_reg != '0) || wchar_reg || weol_reg);
                    end
                    else if (ei_reg < en_reg)
                    begin
                        ei_next    = ei_reg + CC_W'(1);
                        okind_next = bir_pkg::KIND_CHAR;
                        ochar_next = cbuf_reg[ei_reg[RI_W-1:0]];
                        olast_next = !(((ei_reg + CC_W'(1)) < en_reg) || wchar_reg ||
                                       weol_reg);
                    end
                    else if (wchar_reg)
                    begin
                        wchar_next = 1'b0;
                        okind_next = bir_pkg::KIND_CHAR;
                        ochar_next = char_reg;
                        olast_next = !weol_reg;
                    end
                    else
                    begin
                        weol_next  = 1'b0;
                        okind_next = bir_pkg::KIND_EOL;
                        olast_next = 1'b1;
                    end
                    if (olast_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= bir_pkg::PH_STRIP;
            count_reg  <= '0;
            sum_reg    <= '0;
            net_reg    <= 16'sd0;
            ccount_reg <= '0;
            second_reg <= 1'b0;
            wind_reg   <= 1'b0;
            wchar_reg  <= 1'b0;
            weol_reg   <= 1'b0;
            en_reg     <= '0;
            ei_reg     <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            net_reg    <= net_next;
            ccount_reg <= ccount_next;
            second_reg <= second_next;
            wind_reg   <= wind_next;
            wchar_reg  <= wchar_next;
            weol_reg   <= weol_next;
            en_reg     <= en_next;
            ei_reg     <= ei_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg <= amount_next;
        char_reg   <= char_next;
        ovf_reg    <= ovf_next;
        netop_reg  <= netop_next;
        sc_reg     <= sc_next;
        okind_reg  <= okind_next;
        ochar_reg  <= ochar_next;
        osc_reg    <= osc_next;
        oovf_reg   <= oovf_next;
        olast_reg  <= olast_next;
        if (cbuf_we)
        begin
            cbuf_reg[cbuf_widx] <= character;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign kind        = okind_reg;
    assign out_char    = ochar_reg;
    assign space_count = osc_reg;
    assign overflow    = oovf_reg;
    assign last        = olast_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("indent stack count beyond depth");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ccount_reg <= CC_W'(RUN_DEPTH))
        else $error("closer run count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stk_op.pop |-> (count_reg != '0))
        else $error("pop on an empty indent stack");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (ei_reg <= en_reg))
        else $error("closer emission index beyond run length");
`endif

endmodule

FILE: rtl/bir_stack_cell.sv
// ----------------------------------------------------------------------------
// bir_stack_cell: one entry of the indent stack
// Takes the shallower neighbor's part on a push, the deeper neighbor's part
// on a pop, and the shallower input on a load of the top entry.
// ----------------------------------------------------------------------------
module bir_stack_cell #(
    parameter int PART_WIDTH = bir_pkg::PART_WIDTH_DEF
) (
    input  logic                  clk,
    input  bir_pkg::stack_op_t    op,
    input  logic [PART_WIDTH-1:0] from_upper,
    input  logic [PART_WIDTH-1:0] from_lower,
    output logic [PART_WIDTH-1:0] part
);

    logic [PART_WIDTH-1:0] part_reg;
    logic [PART_WIDTH-1:0] part_next;

    always_comb
    begin
        part_next = part_reg;
        if (op.push || op.load)
        begin
            part_next = from_upper;
        end
        else if (op.pop)
        begin
            part_next = from_lower;
        end
    end

    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
    end

    assign part = part_reg;

endmodule

FILE: rtl/bir_stack.sv
// ----------------------------------------------------------------------------
// bir_stack: indent stack as a shifting chain of cells
// The top of the stack always sits in the first cell; pushes shift the chain
// deeper and pops shift it back toward the top.
// ----------------------------------------------------------------------------
module bir_stack #(
    parameter int STACK_DEPTH = bir_pkg::STACK_DEPTH_DEF,
    parameter int PART_WIDTH  = bir_pkg::PART_WIDTH_DEF
) (
    input  logic                  clk,
    input  bir_pkg::stack_op_t    op,
    input  logic [PART_WIDTH-1:0] din,
    output logic [PART_WIDTH-1:0] top
);

    logic [PART_WIDTH-1:0] parts [STACK_DEPTH];
    logic [PART_WIDTH-1:0] upper [STACK_DEPTH];
    logic [PART_WIDTH-1:0] lower [STACK_DEPTH];
    bir_pkg::stack_op_t    cell_op [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign upper[i]   = din;
            assign cell_op[i] = op;
        end
        else
        begin : g_body
            assign upper[i]   = parts[i-1];
            assign cell_op[i] = '{push: op.push, pop: op.pop, load: 1'b0};
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign lower[i] = parts[i];
        end
        else
        begin : g_inner
            assign lower[i] = parts[i+1];
        end

        bir_stack_cell #(
            .PART_WIDTH(PART_WIDTH)
        ) u_cell (
            .clk       (clk),
            .op        (cell_op[i]),
            .from_upper(upper[i]),
            .from_lower(lower[i]),
            .part      (parts[i])
        );
    end

    assign top = parts[0];

endmodule
